// ===== hdl/texmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texmb_pkg: shared types and constants of the mipmapped texture sampler
// Item and configuration structs, register indexes, filter and format codes.
// ----------------------------------------------------------------------------
package texmb_pkg;

   localparam int TEXEL_WORDS_DEF = 32768;
   localparam int MAX_DIM_DEF     = 128;
   localparam int MAX_LEVELS_DEF  = 8;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [2:0] CSR_TEX_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_TEX_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_LEVEL_COUNT  = 3'd2;
   localparam logic [2:0] CSR_WRAP_S       = 3'd3;
   localparam logic [2:0] CSR_WRAP_T       = 3'd4;
   localparam logic [2:0] CSR_MAG_FILTER   = 3'd5;
   localparam logic [2:0] CSR_MIN_FILTER   = 3'd6;
   localparam logic [2:0] CSR_TEXEL_FORMAT = 3'd7;

   localparam logic       FUNC_WRITE  = 1'b0;
   localparam logic       FUNC_SAMPLE = 1'b1;

   localparam logic [1:0] MIN_MIP_NEAREST = 2'd2;
   localparam logic [1:0] MIN_MIP_LINEAR  = 2'd3;

   localparam logic [2:0] FMT_RGB565 = 3'd4;

   typedef struct packed {
      logic              func;
      logic [14:0]       texel_addr;
      logic [31:0]       texel_data;
      logic signed [19:0] coord_u;
      logic signed [19:0] coord_v;
      logic [11:0]       level_of_detail;
   } item_type;

   typedef struct packed {
      logic [7:0] tex_width;
      logic [7:0] tex_height;
      logic [3:0] level_count;
      logic       wrap_s;
      logic       wrap_t;
      logic       mag_filter;
      logic [1:0] min_filter;
      logic [2:0] texel_format;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic out_load;
   } back_status_type;

   // Unpack one texel word into four 8-bit channels, channel c at [8c+7:8c]
   function automatic logic [31:0] texel_channels(input logic [31:0] word,
                                                  input logic [2:0]  fmt);
      logic [31:0] ch;
      logic [4:0]  r5;
      logic [5:0]  g6;
      logic [4:0]  b5;
      begin
         ch = '0;
         r5 = word[15:11];
         g6 = word[10:5];
         b5 = word[4:0];
         if (fmt == FMT_RGB565) begin
            ch[7:0]   = {r5, r5[4:2]};
            ch[15:8]  = {g6, g6[5:4]};
            ch[23:16] = {b5, b5[4:2]};
         end else if (fmt < FMT_RGB565) begin
            for (int c = 0; c < 4; c++) begin
               if (c <= int'(fmt)) ch[8*c +: 8] = word[8*c +: 8];
            end
         end
         texel_channels = ch;
      end
   endfunction

endpackage

// ===== hdl/texture_sampler_mip_bilinear.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_mip_bilinear: mipmapped bilinear texture sampler
// Texel writes and samples enter a request queue; a sequencer fetches texels
// from a single-port texel memory and filters them into Q8.8 channels.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transfer
//  request  | req_push, req_full, req_* fields        | push && !full
//  response | rsp_empty, rsp_pop, rsp_chan_*          | pop && !empty
//  csr      | csr_we, csr_index, csr_wdata            | csr_we
//
//  A write is performed straight from the idle state. A sample walks the mip
//  chain, summing the size of each lower level, then uses the shared remainder
//  unit for wrapping in X and Y (XW = 13 at MAX_DIM 128) and fetches each texel
//  through the single memory port in address, read and accumulate states; a
//  mip-linear sample repeats this for its second level.
//  Reset is synchronous and clears queue, sequencer, configuration and result
//  valid. The queue keeps accepting while a result waits to be popped.
// ----------------------------------------------------------------------------
module texture_sampler_mip_bilinear import texmb_pkg::*; #(
   parameter int TEXEL_WORDS = TEXEL_WORDS_DEF,
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [14:0]        req_texel_addr,
   input  logic [31:0]        req_texel_data,
   input  logic signed [19:0] req_coord_u,
   input  logic signed [19:0] req_coord_v,
   input  logic [11:0]        req_level_of_detail,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_chan_r,
   output logic [15:0]        rsp_chan_g,
   output logic [15:0]        rsp_chan_b,
   output logic [15:0]        rsp_chan_a,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   item_type        push_item, q_item;
   logic            q_valid, q_pop;
   back_status_type back_st;

   assign push_item.func            = req_func;
   assign push_item.texel_addr      = req_texel_addr;
   assign push_item.texel_data      = req_texel_data;
   assign push_item.coord_u         = req_coord_u;
   assign push_item.coord_v         = req_coord_v;
   assign push_item.level_of_detail = req_level_of_detail;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:    cfg_in.tex_width    = csr_wdata;
            CSR_TEX_HEIGHT:   cfg_in.tex_height   = csr_wdata;
            CSR_LEVEL_COUNT:  cfg_in.level_count  = csr_wdata[3:0];
            CSR_WRAP_S:       cfg_in.wrap_s       = csr_wdata[0];
            CSR_WRAP_T:       cfg_in.wrap_t       = csr_wdata[0];
            CSR_MAG_FILTER:   cfg_in.mag_filter   = csr_wdata[0];
            CSR_MIN_FILTER:   cfg_in.min_filter   = csr_wdata[1:0];
            CSR_TEXEL_FORMAT: cfg_in.texel_format = csr_wdata[2:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.tex_width    <= 8'd1;
         cfg_ff.tex_height   <= 8'd1;
         cfg_ff.level_count  <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   texmb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_item (push_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   texmb_back #(
      .TEXEL_WORDS (TEXEL_WORDS),
      .MAX_DIM     (MAX_DIM),
      .MAX_LEVELS  (MAX_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .chan_r    (rsp_chan_r),
      .chan_g    (rsp_chan_g),
      .chan_b    (rsp_chan_b),
      .chan_a    (rsp_chan_a),
      .status    (back_st)
   );

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue or result not cleared by reset");

   a_push_queued: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> q_valid)
      else $error("accepted transaction missing from queue");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      back_st.out_load |=> !rsp_empty)
      else $error("loaded result not presented");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> back_st.idle && q_valid)
      else $error("queue popped while sequencer busy");

endmodule

// ===== hdl/texmb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texmb_front: request queue
// Accepts write and sample transactions and holds them in order for the back.
// ----------------------------------------------------------------------------
module texmb_front import texmb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  item_type push_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   localparam int PTRW = $clog2(QUEUE_DEPTH);

   item_type                slot_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]         wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTRW:0]           count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == (PTRW+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (PTRW+1)'(do_push) - (PTRW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_item;
   end

endmodule

// ===== hdl/texmb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texmb_back: texel memory and filter sequencer
// Executes queued writes, walks the mip chain, wraps or clamps coordinates,
// fetches up to four texels per level, blends them into a registered result.
// ----------------------------------------------------------------------------
module texmb_back import texmb_pkg::*; #(
   parameter int TEXEL_WORDS = TEXEL_WORDS_DEF,
   parameter int MAX_DIM     = MAX_DIM_DEF,
   parameter int MAX_LEVELS  = MAX_LEVELS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            q_valid,
   input  item_type        q_item,
   output logic            q_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [15:0]     chan_r,
   output logic [15:0]     chan_g,
   output logic [15:0]     chan_b,
   output logic [15:0]     chan_a,
   output back_status_type status
);

   localparam int DW   = $clog2(MAX_DIM + 1);
   localparam int AW   = $clog2(TEXEL_WORDS);
   localparam int PW   = 21 + DW;
   localparam int XW   = PW - 16;
   localparam int CNTW = $clog2(XW + 1);
   localparam int SW   = 2 * DW + 3;
   localparam int ACCW = 41;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BASE  = 4'd1;
   localparam logic [3:0] ST_MULT  = 4'd2;
   localparam logic [3:0] ST_SPLIT = 4'd3;
   localparam logic [3:0] ST_MODX  = 4'd4;
   localparam logic [3:0] ST_MODY  = 4'd5;
   localparam logic [3:0] ST_WRAP  = 4'd6;
   localparam logic [3:0] ST_FADDR = 4'd7;
   localparam logic [3:0] ST_FREAD = 4'd8;
   localparam logic [3:0] ST_FACC  = 4'd9;
   localparam logic [3:0] ST_PASS  = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   localparam logic signed [PW-1:0] HALF_TEXEL = PW'(32768);

   function automatic logic [DW-1:0] lvl_dim(input logic [DW-1:0] d, input logic [3:0] k);
      logic [DW-1:0] s;
      begin
         s = d >> k;
         lvl_dim = (s == '0) ? DW'(1) : s;
      end
   endfunction

   function automatic logic [DW-1:0] clamp_dim(input logic [7:0] d);
      begin
         if (d == '0) clamp_dim = DW'(1);
         else if (int'(d) > MAX_DIM) clamp_dim = DW'(MAX_DIM);
         else clamp_dim = DW'(d);
      end
   endfunction

   logic [31:0] texel_mem [TEXEL_WORDS];

   logic [3:0]              state_ff, state_in;
   logic signed [19:0]      u_ff, u_in, v_ff, v_in;
   logic                    bil_ff, bil_in, two_ff, two_in, pass_ff, pass_in;
   logic [3:0]              lv_ff, lv_in, lv1_ff, lv1_in, j_ff, j_in;
   logic [7:0]              lf_ff, lf_in;
   logic [SW-1:0]           base_ff, base_in;
   logic [DW-1:0]           wk_ff, wk_in, hk_ff, hk_in;
   logic signed [PW-1:0]    px_ff, px_in, py_ff, py_in;
   logic signed [XW-1:0]    x0_ff, x0_in, y0_ff, y0_in;
   logic [15:0]             fx_ff, fx_in, fy_ff, fy_in;
   logic [XW-1:0]           mag_ff, mag_in;
   logic                    sgn_ff, sgn_in;
   logic [DW-1:0]           rem_ff, rem_in, xm_ff, xm_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [DW-1:0]           xa_ff, xa_in, xb_ff, xb_in, ya_ff, ya_in, yb_ff, yb_in;
   logic [1:0]              tap_ff, tap_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [32:0]             wgt_ff, wgt_in;
   logic [31:0]             rdata_ff;
   logic [3:0][ACCW-1:0]    acc_ff, acc_in;
   logic [3:0][15:0]        s0_ff, s0_in, res_ff, res_in, out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;

   logic [DW-1:0]           w_eff, h_eff, dw_j, dh_j, msize, mres, ysel, xsel;
   logic [3:0]              lc_eff, maxl, li, l0_mip, l1_mip, l_near;
   logic [4:0]              l1_raw;
   logic [11:0]             lod, lod_cap;
   logic [12:0]             lod_rnd;
   logic [DW:0]             mod_t;
   logic signed [PW-1:0]    ue, ve, we, he;
   logic signed [XW-1:0]    x1, y1, wlast, hlast;
   logic [SW-1:0]           addr_sum;
   logic [SW+AW-1:0]        addr_ext;
   logic [16:0]             wx, wy;
   logic [31:0]             chans;
   logic [ACCW-1:0]         rnd;
   logic [15:0]             s_cur;
   logic [25:0]             blend;
   logic                    mem_we, out_load;

   always_comb begin
      w_eff  = clamp_dim(cfg.tex_width);
      h_eff  = clamp_dim(cfg.tex_height);
      if (cfg.level_count == '0) lc_eff = 4'd1;
      else if (int'(cfg.level_count) > MAX_LEVELS) lc_eff = 4'(MAX_LEVELS);
      else lc_eff = cfg.level_count;
      maxl   = lc_eff - 4'd1;
      lod    = q_item.level_of_detail;
      li     = lod[11:8];
      lod_cap = (lod > {maxl, 8'h00}) ? {maxl, 8'h00} : lod;
      lod_rnd = {1'b0, lod_cap} + 13'd128;
      l_near = lod_rnd[11:8];
      l0_mip = (li > maxl) ? maxl : li;
      l1_raw = {1'b0, li} + 5'(lod[7:0] != 8'h00);
      l1_mip = (l1_raw > {1'b0, maxl}) ? maxl : l1_raw[3:0];
      dw_j   = lvl_dim(w_eff, j_ff);
      dh_j   = lvl_dim(h_eff, j_ff);
      ue     = PW'(u_ff);
      ve     = PW'(v_ff);
      we     = $signed(PW'({1'b0, wk_ff}));
      he     = $signed(PW'({1'b0, hk_ff}));
      msize  = (state_ff == ST_MODX) ? wk_ff : hk_ff;
      mod_t  = {rem_ff, mag_ff[XW-1]};
      mres   = (!sgn_ff || rem_ff == '0) ? rem_ff : msize - rem_ff;
      x1     = x0_ff + XW'(1);
      y1     = y0_ff + XW'(1);
      wlast  = $signed(XW'({1'b0, wk_ff - DW'(1)}));
      hlast  = $signed(XW'({1'b0, hk_ff - DW'(1)}));
      xsel   = tap_ff[0] ? xb_ff : xa_ff;
      ysel   = tap_ff[1] ? yb_ff : ya_ff;
      addr_sum = base_ff + SW'(ysel) * SW'(wk_ff) + SW'(xsel);
      addr_ext = {{AW{1'b0}}, addr_sum};
      wx     = tap_ff[0] ? {1'b0, fx_ff} : 17'h10000 - {1'b0, fx_ff};
      wy     = tap_ff[1] ? {1'b0, fy_ff} : 17'h10000 - {1'b0, fy_ff};
      chans  = texel_channels(rdata_ff, cfg.texel_format);
      mem_we = (state_ff == ST_IDLE) && q_valid && (q_item.func == FUNC_WRITE);
      q_pop  = (state_ff == ST_IDLE) && q_valid;
      out_load = (state_ff == ST_OUT) && (!out_valid_ff || rsp_pop);

      state_in = state_ff;
      u_in = u_ff;  v_in = v_ff;
      bil_in = bil_ff;  two_in = two_ff;  pass_in = pass_ff;
      lv_in = lv_ff;  lv1_in = lv1_ff;  j_in = j_ff;  lf_in = lf_ff;
      base_in = base_ff;  wk_in = wk_ff;  hk_in = hk_ff;
      px_in = px_ff;  py_in = py_ff;  x0_in = x0_ff;  y0_in = y0_ff;
      fx_in = fx_ff;  fy_in = fy_ff;
      mag_in = mag_ff;  sgn_in = sgn_ff;  rem_in = rem_ff;  xm_in = xm_ff;  cnt_in = cnt_ff;
      xa_in = xa_ff;  xb_in = xb_ff;  ya_in = ya_ff;  yb_in = yb_ff;
      tap_in = tap_ff;  addr_in = addr_ff;  wgt_in = wgt_ff;
      acc_in = acc_ff;  s0_in = s0_ff;  res_in = res_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      rnd = '0;
      s_cur = '0;
      blend = '0;

      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_item.func == FUNC_SAMPLE) begin
               u_in = q_item.coord_u;
               v_in = q_item.coord_v;
               pass_in = 1'b0;
               two_in  = 1'b0;
               lf_in   = lod[7:0];
               j_in    = '0;
               base_in = '0;
               if (lod == '0) begin
                  bil_in = cfg.mag_filter;
                  lv_in  = '0;
               end else if (cfg.min_filter == MIN_MIP_NEAREST) begin
                  bil_in = 1'b1;
                  lv_in  = l_near;
               end else if (cfg.min_filter == MIN_MIP_LINEAR) begin
                  bil_in = 1'b1;
                  two_in = 1'b1;
                  lv_in  = l0_mip;
                  lv1_in = l1_mip;
               end else begin
                  bil_in = 1'b0;
                  lv_in  = '0;
               end
               if (cfg.texel_format > FMT_RGB565) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            // accumulate the sizes of the levels below the one sampled
            if (j_ff == lv_ff) begin
               wk_in    = dw_j;
               hk_in    = dh_j;
               state_in = ST_MULT;
            end else begin
               base_in = base_ff + SW'(dw_j) * SW'(dh_j);
               j_in    = j_ff + 4'd1;
            end
         end
         ST_MULT: begin
            px_in = ue * we - (bil_ff ? HALF_TEXEL : '0);
            py_in = ve * he - (bil_ff ? HALF_TEXEL : '0);
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            x0_in  = px_ff[PW-1:16];
            y0_in  = py_ff[PW-1:16];
            fx_in  = px_ff[15:0];
            fy_in  = py_ff[15:0];
            sgn_in = px_ff[PW-1];
            mag_in = px_ff[PW-1] ? XW'(-px_ff[PW-1:16]) : px_ff[PW-1:16];
            rem_in = '0;
            cnt_in = CNTW'(XW);
            state_in = ST_MODX;
         end
         ST_MODX, ST_MODY: begin
            // restoring remainder, one bit of the magnitude per cycle
            if (cnt_ff != '0) begin
               rem_in = (mod_t >= {1'b0, msize}) ? DW'(mod_t - {1'b0, msize}) : DW'(mod_t);
               mag_in = mag_ff << 1;
               cnt_in = cnt_ff - CNTW'(1);
            end else if (state_ff == ST_MODX) begin
               xm_in  = mres;
               sgn_in = y0_ff[XW-1];
               mag_in = y0_ff[XW-1] ? XW'(-y0_ff) : XW'(y0_ff);
               rem_in = '0;
               cnt_in = CNTW'(XW);
               state_in = ST_MODY;
            end else begin
               if (cfg.wrap_t) begin
                  ya_in = mres;
                  yb_in = (mres == hk_ff - DW'(1)) ? '0 : mres + DW'(1);
               end else begin
                  ya_in = (y0_ff < 0) ? '0 : (y0_ff > hlast) ? hk_ff - DW'(1) : DW'(y0_ff);
                  yb_in = (y1 < 0) ? '0 : (y1 > hlast) ? hk_ff - DW'(1) : DW'(y1);
               end
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (cfg.wrap_s) begin
               xa_in = xm_ff;
               xb_in = (xm_ff == wk_ff - DW'(1)) ? '0 : xm_ff + DW'(1);
            end else begin
               xa_in = (x0_ff < 0) ? '0 : (x0_ff > wlast) ? wk_ff - DW'(1) : DW'(x0_ff);
               xb_in = (x1 < 0) ? '0 : (x1 > wlast) ? wk_ff - DW'(1) : DW'(x1);
            end
            tap_in = '0;
            acc_in = '0;
            state_in = ST_FADDR;
         end
         ST_FADDR: begin
            addr_in = addr_ext[AW-1:0];
            wgt_in  = bil_ff ? 33'(wx) * 33'(wy) : 33'h1_0000_0000;
            state_in = ST_FREAD;
         end
         ST_FREAD: begin
            state_in = ST_FACC;
         end
         ST_FACC: begin
            for (int c = 0; c < 4; c++) begin
               acc_in[c] = acc_ff[c] + ACCW'(chans[8*c +: 8]) * ACCW'(wgt_ff);
            end
            if (!bil_ff || tap_ff == 2'd3) begin
               state_in = ST_PASS;
            end else begin
               tap_in   = tap_ff + 2'd1;
               state_in = ST_FADDR;
            end
         end
         ST_PASS: begin
            for (int c = 0; c < 4; c++) begin
               rnd   = acc_ff[c] + ACCW'(32'h0080_0000);
               s_cur = rnd[39:24];
               if (two_ff && !pass_ff) begin
                  s0_in[c] = s_cur;
               end else if (two_ff) begin
                  blend = 26'(s0_ff[c]) * 26'(9'd256 - {1'b0, lf_ff})
                        + 26'(s_cur) * 26'(lf_ff) + 26'd128;
                  res_in[c] = blend[23:8];
               end else begin
                  res_in[c] = s_cur;
               end
            end
            if (two_ff && !pass_ff) begin
               pass_in = 1'b1;
               lv_in   = lv1_ff;
               j_in    = '0;
               base_in = '0;
               state_in = ST_BASE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;  v_ff <= v_in;
      bil_ff <= bil_in;  two_ff <= two_in;  pass_ff <= pass_in;
      lv_ff <= lv_in;  lv1_ff <= lv1_in;  j_ff <= j_in;  lf_ff <= lf_in;
      base_ff <= base_in;  wk_ff <= wk_in;  hk_ff <= hk_in;
      px_ff <= px_in;  py_ff <= py_in;  x0_ff <= x0_in;  y0_ff <= y0_in;
      fx_ff <= fx_in;  fy_ff <= fy_in;
      mag_ff <= mag_in;  sgn_ff <= sgn_in;  rem_ff <= rem_in;  xm_ff <= xm_in;
      cnt_ff <= cnt_in;
      xa_ff <= xa_in;  xb_ff <= xb_in;  ya_ff <= ya_in;  yb_ff <= yb_in;
      tap_ff <= tap_in;  addr_ff <= addr_in;  wgt_ff <= wgt_in;
      acc_ff <= acc_in;  s0_ff <= s0_in;  res_ff <= res_in;  out_ff <= out_in;
   end

   // single port: a write and a read never fall in the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         texel_mem[AW'({{AW{1'b0}}, q_item.texel_addr})] <= q_item.texel_data;
      end
      if (state_ff == ST_FREAD) begin
         rdata_ff <= texel_mem[addr_ff];
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign chan_r          = out_ff[0];
   assign chan_g          = out_ff[1];
   assign chan_b          = out_ff[2];
   assign chan_a          = out_ff[3];
   assign status.idle     = (state_ff == ST_IDLE);
   assign status.out_load = out_load;

endmodule
